>>> rtl/nts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nts_pkg
// Shared constants, tables and types for the note tone sine generator.
// ----------------------------------------------------------------------------
package nts_pkg;

    localparam int SAMPLES_PER_UNIT = 64;
    localparam int SAMPLE_RATE_HZ   = 22050;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int NOTE_COUNT = 87;
    localparam int AMP_FULL   = 20000;
    localparam int AMP_W      = 15;
    localparam int SINE_W     = 31;
    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int CNT_W      = (SAMPLES_PER_UNIT > 1) ? $clog2(SAMPLES_PER_UNIT) : 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [63:0] STEP_DIV    = 64'(100 * SAMPLE_RATE_HZ);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // word kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_ENABLE = 1'b1;

    typedef logic [19:0]       t_freq_table [0:NOTE_COUNT-1];
    typedef logic [31:0]       t_step_table [0:NOTE_COUNT-1];
    typedef logic [SINE_W-1:0] t_sine_table [0:SINE_TABLE_DEPTH];

    // note frequencies in hundredths of Hz
    localparam t_freq_table NOTE_FREQ = '{
        20'd5827, 20'd6174, 20'd6541, 20'd6930, 20'd7342, 20'd7778, 20'd8241,
        20'd8731, 20'd9250, 20'd9800, 20'd10383, 20'd11000, 20'd11654, 20'd12347,
        20'd13081, 20'd13859, 20'd14683, 20'd15556, 20'd16481, 20'd17461,
        20'd18500, 20'd19600, 20'd20765, 20'd22000, 20'd23308, 20'd24694,
        20'd26163, 20'd27718, 20'd29366, 20'd31113, 20'd32963, 20'd34923,
        20'd36999, 20'd39200, 20'd41530, 20'd44000, 20'd46616, 20'd49388,
        20'd52325, 20'd55437, 20'd58733, 20'd62225, 20'd65926, 20'd69846,
        20'd73999, 20'd78399, 20'd83061, 20'd88000, 20'd93233, 20'd98777,
        20'd104650, 20'd110873, 20'd117466, 20'd124451, 20'd131851, 20'd139691,
        20'd147998, 20'd156798, 20'd166122, 20'd176000, 20'd186466, 20'd197553,
        20'd209300, 20'd221746, 20'd234932, 20'd248902, 20'd263702, 20'd279383,
        20'd295996, 20'd313596, 20'd332244, 20'd352000, 20'd372931, 20'd395107,
        20'd418601, 20'd443492, 20'd469864, 20'd497803, 20'd527404, 20'd558765,
        20'd591991, 20'd627193, 20'd664488, 20'd704000, 20'd745862, 20'd790213,
        20'd837202
    };

    // phase increment per sample, rounded fraction of a turn
    function automatic t_step_table f_build_steps();
        t_step_table tbl;
        int i;
        for (i = 0; i < NOTE_COUNT; i++) begin
            tbl[i] = 32'(((64'(NOTE_FREQ[i]) << 32) + (STEP_DIV >> 1)) / STEP_DIV);
        end
        return tbl;
    endfunction

    // quarter-wave sine in Q30, Taylor series to x^15
    function automatic t_sine_table f_build_quarter_sine();
        t_sine_table tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        int k;
        int n;
        for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            if (neg >= pos) begin
                tbl[k] = '0;
            end else begin
                pos = pos - neg;
                if (pos > ONE_Q30) begin
                    pos = ONE_Q30;
                end
                tbl[k] = SINE_W'(pos);
            end
        end
        return tbl;
    endfunction

    localparam t_step_table PHASE_STEP   = f_build_steps();
    localparam t_sine_table QUARTER_SINE = f_build_quarter_sine();

    // amplitude for a volume level, saturated at nine
    function automatic logic [AMP_W-1:0] f_amp(input logic [CFG_DATA_W-1:0] vol);
        logic [AMP_W-1:0] amp;
        case (vol)
            4'd0:    amp = AMP_W'(AMP_FULL * 0 / 9);
            4'd1:    amp = AMP_W'(AMP_FULL * 1 / 9);
            4'd2:    amp = AMP_W'(AMP_FULL * 2 / 9);
            4'd3:    amp = AMP_W'(AMP_FULL * 3 / 9);
            4'd4:    amp = AMP_W'(AMP_FULL * 4 / 9);
            4'd5:    amp = AMP_W'(AMP_FULL * 5 / 9);
            4'd6:    amp = AMP_W'(AMP_FULL * 6 / 9);
            4'd7:    amp = AMP_W'(AMP_FULL * 7 / 9);
            4'd8:    amp = AMP_W'(AMP_FULL * 8 / 9);
            default: amp = AMP_W'(AMP_FULL);
        endcase
        return amp;
    endfunction

    // flags carried with each output word
    typedef struct packed {
        logic sample_valid;
        logic playing;
        logic last;
    } t_flags;

    typedef struct packed {
        logic   load;
        logic   dec_units;
        logic   issue;
        t_flags flags;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic units_zero;
        logic sound_en;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/nts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nts_ctrl
// Sequencer: accepts words, issues output words into the datapath.
// ----------------------------------------------------------------------------
module nts_ctrl
    import nts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_action,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_cnt_last;

    assign w_cnt_last = (r_count == CNT_W'(SAMPLES_PER_UNIT - 1));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        o_in_ready = (r_state == ST_IDLE) && i_status.adv;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.adv) begin
                    if (i_action == ACT_START) begin
                        o_cmd.load = 1'b1;
                    end else if (i_status.units_zero) begin
                        o_cmd.issue      = 1'b1;
                        o_cmd.flags.last = 1'b1;
                    end else if (!i_status.sound_en) begin
                        o_cmd.dec_units     = 1'b1;
                        o_cmd.issue         = 1'b1;
                        o_cmd.flags.playing = 1'b1;
                        o_cmd.flags.last    = 1'b1;
                    end else begin
                        o_cmd.dec_units          = 1'b1;
                        o_cmd.issue              = 1'b1;
                        o_cmd.flags.sample_valid = 1'b1;
                        o_cmd.flags.playing      = 1'b1;
                        o_cmd.flags.last         = (SAMPLES_PER_UNIT == 1);
                        if (SAMPLES_PER_UNIT > 1) begin
                            n_state = ST_RUN;
                            n_count = CNT_W'(1);
                        end
                    end
                end
            end
            ST_RUN: begin
                if (i_status.adv) begin
                    o_cmd.issue              = 1'b1;
                    o_cmd.flags.sample_valid = 1'b1;
                    o_cmd.flags.playing      = 1'b1;
                    o_cmd.flags.last         = w_cnt_last;
                    n_count                  = r_count + CNT_W'(1);
                    if (w_cnt_last) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_in_ready)
        else $error("input accepted during sample burst");

    a_run_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_count != '0))
        else $error("burst counter lost position");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && o_cmd.issue && o_cmd.flags.last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after last word");

endmodule
`default_nettype wire

>>> rtl/nts_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nts_datapath
// Note state, phase accumulator and the sine/amplitude output pipeline.
// ----------------------------------------------------------------------------
module nts_datapath
    import nts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic [6:0]            i_note,
    input  wire logic [15:0]           i_length,
    input  wire logic                  i_envelope_on,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [15:0]                o_sample,
    output t_flags                     o_flags
);

    logic [31:0]      r_phase_acc;
    logic [31:0]      r_phase_step;
    logic [15:0]      r_units_left;
    logic             r_tone_on;
    logic [AMP_W-1:0] r_amp;
    logic             r_sound_en;

    logic             w_adv;
    logic             w_tone;
    logic [6:0]       w_note_sat;
    logic [29+IDX_W:0] w_idx_prod;
    logic [IDX_W-1:0] w_idx_raw;
    logic [IDX_W-1:0] w_idx;
    logic [SINE_W+AMP_W-1:0] w_prod;

    // pipeline: s1 index, s2 table value, s3 scaled magnitude, out sample
    logic              r_s1_valid;
    t_flags            r_s1_flags;
    logic              r_s1_tone;
    logic              r_s1_neg;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s2_valid;
    t_flags            r_s2_flags;
    logic              r_s2_tone;
    logic              r_s2_neg;
    logic [SINE_W-1:0] r_s2_sine;
    logic              r_s3_valid;
    t_flags            r_s3_flags;
    logic              r_s3_tone;
    logic              r_s3_neg;
    logic [15:0]       r_s3_mag;
    logic              r_out_valid;
    t_flags            r_out_flags;
    logic [15:0]       r_out_sample;

    assign w_adv = !r_out_valid || i_out_ready;

    assign o_status.adv        = w_adv;
    assign o_status.units_zero = (r_units_left == 16'd0);
    assign o_status.sound_en   = r_sound_en;

    assign w_tone     = i_cmd.flags.sample_valid && r_tone_on;
    assign w_note_sat = (i_note > 7'(NOTE_COUNT - 1)) ? 7'(NOTE_COUNT - 1) : i_note;

    assign w_idx_prod = (30 + IDX_W)'(r_phase_acc[29:0])
                      * (30 + IDX_W)'(SINE_TABLE_DEPTH);
    assign w_idx_raw  = w_idx_prod[29+IDX_W:30];
    assign w_idx      = r_phase_acc[30] ? (IDX_W'(SINE_TABLE_DEPTH) - w_idx_raw)
                                        : w_idx_raw;

    assign w_prod = (SINE_W + AMP_W)'(r_s2_sine) * (SINE_W + AMP_W)'(r_amp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc  <= '0;
            r_phase_step <= '0;
            r_units_left <= '0;
            r_tone_on    <= 1'b0;
            r_amp        <= AMP_W'(AMP_FULL);
            r_sound_en   <= 1'b1;
        end else begin
            if (i_cmd.load) begin
                r_phase_step <= PHASE_STEP[w_note_sat];
                r_units_left <= i_length;
                r_tone_on    <= i_envelope_on;
            end
            if (i_cmd.dec_units) begin
                r_units_left <= r_units_left - 16'd1;
            end
            if (i_cmd.issue && w_tone) begin
                r_phase_acc <= r_phase_acc + r_phase_step;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_VOLUME:       r_amp      <= f_amp(i_cfg_data);
                    REG_SOUND_ENABLE: r_sound_en <= i_cfg_data[0];
                    default:          r_amp      <= r_amp;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_cmd.issue;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_flags   <= i_cmd.flags;
            r_s1_tone    <= w_tone;
            r_s1_neg     <= r_phase_acc[31];
            r_s1_idx     <= w_idx;
            r_s2_flags   <= r_s1_flags;
            r_s2_tone    <= r_s1_tone;
            r_s2_neg     <= r_s1_neg;
            r_s2_sine    <= QUARTER_SINE[r_s1_idx];
            r_s3_flags   <= r_s2_flags;
            r_s3_tone    <= r_s2_tone;
            r_s3_neg     <= r_s2_neg;
            r_s3_mag     <= w_prod[45:30];
            r_out_flags  <= r_s3_flags;
            if (!r_s3_tone) begin
                r_out_sample <= '0;
            end else if (r_s3_neg) begin
                r_out_sample <= 16'd0 - r_s3_mag;
            end else begin
                r_out_sample <= r_s3_mag;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_flags     = r_out_flags;

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_flags.sample_valid) |-> (r_out_sample == 16'd0))
        else $error("nonzero sample on a word without a sample");

    a_sample_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_sample) <= 16'sd20000
                         && $signed(r_out_sample) >= -16'sd20000))
        else $error("sample beyond full amplitude");

    a_ended_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_flags.playing) |-> r_out_flags.last)
        else $error("ended-note word not marked last");

    a_phase_held_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && !i_cmd.load) |=> $stable(r_phase_acc))
        else $error("phase moved while output stalled");

endmodule
`default_nettype wire

>>> rtl/note_tone_sine_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// note_tone_sine_generator
// Sine tone synthesizer driven by start and step words.
// ----------------------------------------------------------------------------
// A start word (tuser 0) loads note, length and envelope when accepted and
// produces nothing. A step word that produces samples yields SAMPLES_PER_UNIT
// samples (64): the phase accumulator issues one sample per cycle while the
// output is not stalled, and the next word is taken once the last sample
// has been issued. A step on an ended note or with sound disabled yields one
// word. Issued samples pass through the registered stages index, sine table
// read, amplitude multiply, output register; a stalled output port holds the whole pipe.
// ----------------------------------------------------------------------------
module note_tone_sine_generator
    import nts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [23:0]           i_s_axis_tdata,  // note[6:0], length[22:7], envelope_on[23]
    input  wire logic                  i_s_axis_tuser,  // action
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [15:0]                o_m_axis_tdata,  // sample[15:0]
    output logic [1:0]                 o_m_axis_tuser,  // sample_valid[0], playing[1]
    output logic                       o_m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    t_flags  w_flags;

    assign o_cfg_ready = 1'b1;

    nts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_action   (i_s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    nts_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_note        (i_s_axis_tdata[6:0]),
        .i_length      (i_s_axis_tdata[22:7]),
        .i_envelope_on (i_s_axis_tdata[23]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_sample      (o_m_axis_tdata),
        .o_flags       (w_flags)
    );

    assign o_m_axis_tuser = {w_flags.playing, w_flags.sample_valid};
    assign o_m_axis_tlast = w_flags.last;

endmodule
`default_nettype wire
